FILE: sv/c_subset_token_scanner_macros.svh
// assertion macros for the token scanner
`ifndef C_SUBSET_TOKEN_SCANNER_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_MACROS_SVH
// property checked on every edge outside reset
`define CST_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// property checked during reset as well
`define CST_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`endif

FILE: sv/cst_pkg.sv
// shared types, constants and tables of the token scanner
package cst_pkg;

   localparam int POS_BITS = 24;
   localparam int LEN_BITS = 10;
   localparam logic [LEN_BITS-1:0] MAX_LEN = 10'd1023;
   localparam int NUM_KW = 15;
   localparam int OUT_DEPTH = 4;

   localparam logic [5:0] K_IDENT = 6'd0;
   localparam logic [5:0] K_INT = 6'd1;
   localparam logic [5:0] K_CHAR = 6'd2;
   localparam logic [5:0] K_STRING = 6'd3;
   localparam logic [5:0] K_KW_BASE = 6'd4;
   localparam logic [5:0] K_PUNCT_BASE = 6'd19;
   localparam logic [5:0] K_LT = 6'd32;
   localparam logic [5:0] K_LE = 6'd33;
   localparam logic [5:0] K_GT = 6'd34;
   localparam logic [5:0] K_GE = 6'd35;
   localparam logic [5:0] K_NE = 6'd36;
   localparam logic [5:0] K_EQEQ = 6'd37;
   localparam logic [5:0] K_ASSIGN = 6'd38;
   localparam logic [5:0] K_UNKNOWN = 6'd39;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]          token_kind;
      logic [POS_BITS-1:0] start_offset;
      logic [LEN_BITS-1:0] token_length;
      logic [15:0]         token_line;
      logic [7:0]          char_value;
      logic                error_flag;
      logic                last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_LT, M_GT, M_BANG, M_EQ,
      M_CHAR_OPEN, M_CHAR_BODY
   } mode_type;

   typedef struct packed {
      logic [7:0] code;
      logic [7:0] low;
      logic       eoi;
      logic       alpha;
      logic       digit;
      logic       ident_ch;
      logic       space;
      logic       newline;
      logic       punct;
      logic [3:0] punct_idx;
      logic       lt;
      logic       gt;
      logic       bang;
      logic       eq;
      logic       dquote;
      logic       squote;
      logic       str_ok;
      logic       char_ok;
   } class_type;

   function automatic logic [2:0] kw_len(input logic [3:0] k);
      case (k)
         4'd0: kw_len = 3'd5; 4'd1: kw_len = 3'd3; 4'd2: kw_len = 3'd4;
         4'd3: kw_len = 3'd4; 4'd4: kw_len = 3'd4; 4'd5: kw_len = 3'd2;
         4'd6: kw_len = 3'd4; 4'd7: kw_len = 3'd6; 4'd8: kw_len = 3'd4;
         4'd9: kw_len = 3'd5; 4'd10: kw_len = 3'd3; 4'd11: kw_len = 3'd5;
         4'd12: kw_len = 3'd6; 4'd13: kw_len = 3'd6; 4'd14: kw_len = 3'd7;
         default: kw_len = 3'd0;
      endcase
   endfunction

   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] p);
      logic [55:0] s;
      case (k)
         4'd0: s = "const  "; 4'd1: s = "int    "; 4'd2: s = "char   ";
         4'd3: s = "void   "; 4'd4: s = "main   "; 4'd5: s = "if     ";
         4'd6: s = "else   "; 4'd7: s = "switch "; 4'd8: s = "case   ";
         4'd9: s = "while  "; 4'd10: s = "for    "; 4'd11: s = "scanf  ";
         4'd12: s = "printf "; 4'd13: s = "return "; 4'd14: s = "default";
         default: s = '0;
      endcase
      // first letter sits in the top byte
      kw_char = (p == 3'd7) ? 8'd0 : s[8'(6 - p) * 8 +: 8];
   endfunction

   function automatic class_type classify(input req_type r);
      class_type c;
      logic [7:0] b;
      b = r.char_code;
      c = '0;
      c.code = b;
      c.eoi = r.end_of_input;
      c.alpha = (b inside {[8'h61:8'h7a], [8'h41:8'h5a]});
      c.digit = (b inside {[8'h30:8'h39]});
      c.low = (b inside {[8'h41:8'h5a]}) ? b + 8'd32 : b;
      c.ident_ch = c.alpha | c.digit | (b == 8'h5f);
      c.space = (b inside {8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c});
      c.newline = (b == 8'h0a);
      c.punct = 1'b1;
      case (b)
         8'h2b: c.punct_idx = 4'd0;  8'h2d: c.punct_idx = 4'd1;
         8'h2a: c.punct_idx = 4'd2;  8'h2f: c.punct_idx = 4'd3;
         8'h3a: c.punct_idx = 4'd4;  8'h3b: c.punct_idx = 4'd5;
         8'h2c: c.punct_idx = 4'd6;  8'h28: c.punct_idx = 4'd7;
         8'h29: c.punct_idx = 4'd8;  8'h5b: c.punct_idx = 4'd9;
         8'h5d: c.punct_idx = 4'd10; 8'h7b: c.punct_idx = 4'd11;
         8'h7d: c.punct_idx = 4'd12;
         default: begin
            c.punct = 1'b0;
            c.punct_idx = 4'd0;
         end
      endcase
      c.lt = (b == 8'h3c);
      c.gt = (b == 8'h3e);
      c.bang = (b == 8'h21);
      c.eq = (b == 8'h3d);
      c.dquote = (b == 8'h22);
      c.squote = (b == 8'h27);
      c.str_ok = (b inside {8'd32, 8'd33, [8'd35:8'd126]});
      c.char_ok = c.ident_ch | (b inside {8'h2b, 8'h2d, 8'h2a, 8'h2f});
      return c;
   endfunction

endpackage

FILE: sv/cst_front.sv
// front end: classifies incoming bytes into a two-entry queue
module cst_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cst_pkg::req_type    req_data,
   output logic                q_valid,
   input  logic                q_take,
   output cst_pkg::class_type  q_data
);

   cst_pkg::class_type slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic       push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid & ~req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = slot_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ q_take;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= cst_pkg::classify(req_data);
      end
   end

endmodule

FILE: sv/cst_back.sv
// back end: scanner state, token building and result queue
`include "c_subset_token_scanner_macros.svh"
module cst_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_take,
   input  cst_pkg::class_type  q_data,
   input  logic                csr_we,
   input  logic [15:0]         csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cst_pkg::rsp_type    rsp_data
);

   localparam int PB = cst_pkg::POS_BITS;
   localparam int LB = cst_pkg::LEN_BITS;

   cst_pkg::mode_type   mode_ff, mode_in;
   logic [14:0]         kw_ff, kw_in;
   logic [LB-1:0]       len_ff, len_in;
   logic [PB-1:0]       start_ff, start_in, pos_ff, pos_in;
   logic [15:0]         line_ff, line_in, first_ff;
   logic [7:0]          held_ff, held_in;
   logic                perr_ff, perr_in;

   cst_pkg::rsp_type    out_mem [cst_pkg::OUT_DEPTH];
   logic [1:0]          owp_ff, orp_ff;
   logic [2:0]          ocnt_ff;
   logic                pop;

   cst_pkg::rsp_type    ra, rb;
   logic                ra_v, rb_v;
   cst_pkg::class_type  c;

   // finish-token fields for the token in progress
   logic                f_v, f_err;
   logic [5:0]          f_kind, id_kind;
   logic [LB-1:0]       f_len, ext_len;
   logic [7:0]          f_cv;
   logic                ext_err, rescan;
   logic [14:0]         narrow0, narrow_cur;

   assign c = q_data;
   assign q_take = q_valid & (ocnt_ff <= 3'd2);
   assign pop = rsp_valid & ~rsp_stall;
   assign rsp_valid = (ocnt_ff != 3'd0);
   assign rsp_data = out_mem[orp_ff];

   always_comb begin
      for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
         narrow_cur[k] = kw_ff[k] && ({7'd0, cst_pkg::kw_len(4'(k))} > len_ff)
            && (c.low == cst_pkg::kw_char(4'(k), len_ff[2:0]));
         narrow0[k] = (c.low == cst_pkg::kw_char(4'(k), 3'd0));
      end
      id_kind = cst_pkg::K_IDENT;
      for (int k = 0; k < cst_pkg::NUM_KW; k++) begin
         if (kw_ff[k] && ({7'd0, cst_pkg::kw_len(4'(k))} == len_ff) && !perr_ff)
            id_kind = cst_pkg::K_KW_BASE + 6'(k);
      end
      ext_len = (len_ff >= cst_pkg::MAX_LEN) ? cst_pkg::MAX_LEN : len_ff + 1'b1;
      ext_err = perr_ff | (len_ff >= cst_pkg::MAX_LEN);
   end

   always_comb begin
      f_v = 1'b1;
      f_err = perr_ff;
      f_len = len_ff;
      f_cv = 8'd0;
      f_kind = cst_pkg::K_UNKNOWN;
      case (mode_ff)
         cst_pkg::M_IDENT:     f_kind = id_kind;
         cst_pkg::M_NUMBER:    f_kind = cst_pkg::K_INT;
         cst_pkg::M_STRING: begin
            f_kind = cst_pkg::K_STRING;
            f_err = 1'b1;
         end
         cst_pkg::M_LT: begin
            f_kind = cst_pkg::K_LT;
            f_len = LB'(1);
         end
         cst_pkg::M_GT: begin
            f_kind = cst_pkg::K_GT;
            f_len = LB'(1);
         end
         cst_pkg::M_BANG: begin
            f_kind = cst_pkg::K_UNKNOWN;
            f_len = LB'(1);
            f_err = 1'b1;
         end
         cst_pkg::M_EQ: begin
            f_kind = cst_pkg::K_ASSIGN;
            f_len = LB'(1);
         end
         cst_pkg::M_CHAR_OPEN: begin
            f_kind = cst_pkg::K_CHAR;
            f_len = LB'(1);
            f_err = 1'b1;
         end
         cst_pkg::M_CHAR_BODY: begin
            f_kind = cst_pkg::K_CHAR;
            f_len = LB'(2);
            f_cv = held_ff;
            f_err = 1'b1;
         end
         default: f_v = 1'b0;
      endcase
   end

   // next state and the up to two tokens of this transaction
   always_comb begin
      mode_in = mode_ff;
      kw_in = kw_ff;
      len_in = len_ff;
      start_in = start_ff;
      pos_in = pos_ff;
      line_in = line_ff;
      held_in = held_ff;
      perr_in = perr_ff;
      ra = '0;
      rb = '0;
      ra_v = 1'b0;
      rb_v = 1'b0;
      rescan = 1'b0;
      ra.token_line = line_ff;
      rb.token_line = line_ff;
      ra.start_offset = start_ff;
      rb.start_offset = pos_ff;
      rb.token_length = LB'(1);
      if (q_take) begin
         if (c.eoi) begin
            ra_v = f_v;
            ra.token_kind = f_kind;
            ra.token_length = f_len;
            ra.char_value = f_cv;
            ra.error_flag = f_err;
            mode_in = cst_pkg::M_IDLE;
            if (f_v) perr_in = 1'b0;
         end else begin
            case (mode_ff)
               cst_pkg::M_IDENT: begin
                  if (c.ident_ch) begin
                     kw_in = narrow_cur;
                     len_in = ext_len;
                     perr_in = ext_err;
                  end else rescan = 1'b1;
               end
               cst_pkg::M_NUMBER: begin
                  if (c.digit) begin
                     len_in = ext_len;
                     perr_in = ext_err;
                  end else rescan = 1'b1;
               end
               cst_pkg::M_STRING: begin
                  if (c.dquote) begin
                     ra_v = 1'b1;
                     ra.token_kind = cst_pkg::K_STRING;
                     ra.token_length = ext_len;
                     ra.error_flag = ext_err | (len_ff == LB'(1));
                     mode_in = cst_pkg::M_IDLE;
                     perr_in = 1'b0;
                  end else if (c.str_ok) begin
                     len_in = ext_len;
                     perr_in = ext_err;
                  end else rescan = 1'b1;
               end
               cst_pkg::M_LT, cst_pkg::M_GT, cst_pkg::M_BANG, cst_pkg::M_EQ: begin
                  if (c.eq) begin
                     ra_v = 1'b1;
                     ra.token_length = LB'(2);
                     case (mode_ff)
                        cst_pkg::M_LT:   ra.token_kind = cst_pkg::K_LE;
                        cst_pkg::M_GT:   ra.token_kind = cst_pkg::K_GE;
                        cst_pkg::M_BANG: ra.token_kind = cst_pkg::K_NE;
                        default:         ra.token_kind = cst_pkg::K_EQEQ;
                     endcase
                     mode_in = cst_pkg::M_IDLE;
                     perr_in = 1'b0;
                  end else rescan = 1'b1;
               end
               cst_pkg::M_CHAR_OPEN: begin
                  if (c.squote) begin
                     ra_v = 1'b1;
                     ra.token_kind = cst_pkg::K_CHAR;
                     ra.token_length = LB'(2);
                     ra.error_flag = 1'b1;
                     mode_in = cst_pkg::M_IDLE;
                     perr_in = 1'b0;
                  end else if (c.newline) begin
                     rescan = 1'b1;
                  end else begin
                     held_in = c.code;
                     perr_in = ~c.char_ok;
                     mode_in = cst_pkg::M_CHAR_BODY;
                  end
               end
               cst_pkg::M_CHAR_BODY: begin
                  if (c.squote) begin
                     ra_v = 1'b1;
                     ra.token_kind = cst_pkg::K_CHAR;
                     ra.token_length = LB'(3);
                     ra.char_value = held_ff;
                     ra.error_flag = perr_ff;
                     mode_in = cst_pkg::M_IDLE;
                     perr_in = 1'b0;
                  end else rescan = 1'b1;
               end
               default: begin
                  mode_in = cst_pkg::M_IDLE;
                  rescan = 1'b1;
               end
            endcase
            if (rescan) begin
               // flush whatever was in progress, then treat the byte as fresh
               ra_v = f_v;
               ra.token_kind = f_kind;
               ra.token_length = f_len;
               ra.char_value = f_cv;
               ra.error_flag = f_err;
               mode_in = cst_pkg::M_IDLE;
               if (f_v) perr_in = 1'b0;
               if (c.space) begin
               end else if (c.newline) begin
                  line_in = line_ff + 16'd1;
               end else if (c.punct) begin
                  rb_v = 1'b1;
                  rb.token_kind = cst_pkg::K_PUNCT_BASE + {2'b00, c.punct_idx};
               end else if (c.lt | c.gt | c.bang | c.eq | c.digit | c.dquote
                            | c.squote | c.alpha | (c.code == 8'h5f)) begin
                  start_in = pos_ff;
                  len_in = LB'(1);
                  perr_in = 1'b0;
                  if (c.lt) mode_in = cst_pkg::M_LT;
                  else if (c.gt) mode_in = cst_pkg::M_GT;
                  else if (c.bang) mode_in = cst_pkg::M_BANG;
                  else if (c.eq) mode_in = cst_pkg::M_EQ;
                  else if (c.digit) mode_in = cst_pkg::M_NUMBER;
                  else if (c.dquote) mode_in = cst_pkg::M_STRING;
                  else if (c.squote) mode_in = cst_pkg::M_CHAR_OPEN;
                  else begin
                     mode_in = cst_pkg::M_IDENT;
                     kw_in = narrow0;
                  end
               end else begin
                  rb_v = 1'b1;
                  rb.token_kind = cst_pkg::K_UNKNOWN;
                  rb.error_flag = 1'b1;
               end
            end
            pos_in = pos_ff + 1'b1;
         end
      end
      ra.last_result = ~rb_v;
      rb.last_result = 1'b1;
      if (csr_we) line_in = csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cst_pkg::M_IDLE;
         kw_ff <= '1;
         len_ff <= '0;
         start_ff <= '0;
         pos_ff <= '0;
         line_ff <= 16'd1;
         first_ff <= 16'd1;
         held_ff <= '0;
         perr_ff <= 1'b0;
         owp_ff <= '0;
         orp_ff <= '0;
         ocnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         kw_ff <= kw_in;
         len_ff <= len_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         if (csr_we) first_ff <= csr_wdata;
         held_ff <= held_in;
         perr_ff <= perr_in;
         owp_ff <= owp_ff + {1'b0, ra_v} + {1'b0, rb_v};
         orp_ff <= orp_ff + {1'b0, pop};
         ocnt_ff <= ocnt_ff + {2'b0, ra_v} + {2'b0, rb_v} - {2'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (ra_v) out_mem[owp_ff] <= ra;
      if (rb_v) out_mem[owp_ff + {1'b0, ra_v}] <= rb;
   end

   `CST_CHECK(a_out_bound, ocnt_ff <= 3'd4, "result queue overflow")
   `CST_CHECK(a_take_room, q_take |-> ocnt_ff <= 3'd2, "item taken without room")
   `CST_CHECK(a_second_last, (q_take && rb_v) |-> !ra.last_result, "bad last mark")
   `CST_CHECK(a_first_line, csr_we |=> first_ff == line_ff, "line not loaded")

endmodule

FILE: sv/c_subset_token_scanner.sv
// top level of the byte-stream token scanner
// Usage:
//  req_ channel carries one source byte (or an end-of-input mark) per transaction;
//  rsp_ channel carries token descriptors, 0 to 2 per input transaction, with
//  last_result set on the final one. A transaction is accepted when valid is high
//  and stall is low.
//  csr_we/csr_wdata load first_line; it also reloads the running line count.
//  Write it only while the scanner is idle.
//  Throughput: one byte per cycle while the result queue has room; a byte that
//  yields two tokens sends them one at a time through the single result port.
//  Once the byte that completes a token is accepted, the token reaches rsp_
//  through the front queue register and then the result queue.
//  The front queue holds two bytes and the result queue four descriptors; the
//  scanner only takes a byte when two result slots are free, so a stalled receiver
//  backs up into req_stall after a few transactions and nothing is lost.
//  Reset (synchronous): scanner idle, position 0, first_line and line count 1,
//  both queues empty.
module c_subset_token_scanner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cst_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cst_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   logic               q_valid, q_take;
   cst_pkg::class_type q_data;

   cst_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
   );

   cst_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_data(q_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

endmodule

FILE: dv/c_subset_token_scanner_checker.sv
// checker for the token scanner: watches both channels, predicts tokens and compares
`timescale 1ns / 100ps
module c_subset_token_scanner_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  cst_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  cst_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [15:0]      csr_wdata,
   output int               fail_count,
   output int               tokens_pending
);

   cst_pkg::rsp_type token_queue[$];

   cst_pkg::mode_type mode;
   logic [14:0]       kw_mask;
   logic [9:0]        cur_len;
   logic [23:0]       tok_start;
   logic [23:0]       byte_pos;
   logic [15:0]       line_num;
   logic [7:0]        held;
   logic              perr;
   logic [5:0]        emitted;

   string kw_names[15] = '{"const", "int", "char", "void", "main", "if", "else", "switch",
                           "case", "while", "for", "scanf", "printf", "return", "default"};
   byte   punct_set[13] = '{"+", "-", "*", "/", ":", ";", ",", "(", ")", "[", "]", "{", "}"};

   assign tokens_pending = token_queue.size();

   function automatic bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_num(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   task automatic push_token(logic [5:0] kind, logic [23:0] st, logic [9:0] len,
                             logic [7:0] cv, logic err);
      cst_pkg::rsp_type t;
      t.token_kind = kind;
      t.start_offset = st;
      t.token_length = len;
      t.token_line = line_num;
      t.char_value = cv;
      t.error_flag = err;
      t.last_result = 1'b0;
      token_queue.push_back(t);
      emitted++;
   endtask

   task automatic narrow(logic [7:0] b);
      logic [7:0] lb;
      string s;
      lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      for (int k = 0; k < 15; k++) begin
         s = kw_names[k];
         if (cur_len >= s.len() || lb != s[cur_len])
            kw_mask[k] = 1'b0;
      end
   endtask

   task automatic grow();
      if (cur_len >= cst_pkg::MAX_LEN) begin
         cur_len = cst_pkg::MAX_LEN;
         perr = 1'b1;
      end else begin
         cur_len++;
      end
   endtask

   task automatic flush_token();
      logic [5:0] kind;
      logic [9:0] len;
      logic [7:0] cv;
      logic       err;
      string      s;
      kind = cst_pkg::K_IDENT;
      len = cur_len;
      cv = 8'd0;
      err = perr;
      case (mode)
         cst_pkg::M_IDENT: begin
            if (!err)
               for (int k = 0; k < 15; k++) begin
                  s = kw_names[k];
                  if (kw_mask[k] && s.len() == cur_len) kind = cst_pkg::K_KW_BASE + 6'(k);
               end
         end
         cst_pkg::M_NUMBER: kind = cst_pkg::K_INT;
         cst_pkg::M_STRING: begin kind = cst_pkg::K_STRING; err = 1'b1; end
         cst_pkg::M_LT: begin kind = cst_pkg::K_LT; len = 10'd1; end
         cst_pkg::M_GT: begin kind = cst_pkg::K_GT; len = 10'd1; end
         cst_pkg::M_BANG: begin kind = cst_pkg::K_UNKNOWN; len = 10'd1; err = 1'b1; end
         cst_pkg::M_EQ: begin kind = cst_pkg::K_ASSIGN; len = 10'd1; end
         cst_pkg::M_CHAR_OPEN: begin kind = cst_pkg::K_CHAR; len = 10'd1; err = 1'b1; end
         cst_pkg::M_CHAR_BODY: begin
            kind = cst_pkg::K_CHAR;
            len = 10'd2;
            cv = held;
            err = 1'b1;
         end
         default: begin
            mode = cst_pkg::M_IDLE;
            return;
         end
      endcase
      push_token(kind, tok_start, len, cv, err);
      mode = cst_pkg::M_IDLE;
      perr = 1'b0;
   endtask

   task automatic open_token(cst_pkg::mode_type m, logic [23:0] p);
      mode = m;
      tok_start = p;
      cur_len = 10'd1;
      perr = 1'b0;
   endtask

   task automatic scan_fresh(logic [7:0] b, logic [23:0] p);
      if (b inside {8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c}) return;
      if (b == 8'h0a) begin
         line_num++;
         return;
      end
      for (int i = 0; i < 13; i++)
         if (b == punct_set[i]) begin
            push_token(cst_pkg::K_PUNCT_BASE + 6'(i), p, 10'd1, 8'd0, 1'b0);
            return;
         end
      if (b == "<") open_token(cst_pkg::M_LT, p);
      else if (b == ">") open_token(cst_pkg::M_GT, p);
      else if (b == "!") open_token(cst_pkg::M_BANG, p);
      else if (b == "=") open_token(cst_pkg::M_EQ, p);
      else if (is_letter(b) || b == "_") begin
         open_token(cst_pkg::M_IDENT, p);
         kw_mask = '1;
         cur_len = 10'd0;
         narrow(b);
         cur_len = 10'd1;
      end
      else if (is_num(b)) open_token(cst_pkg::M_NUMBER, p);
      else if (b == 8'h22) open_token(cst_pkg::M_STRING, p);
      else if (b == 8'h27) open_token(cst_pkg::M_CHAR_OPEN, p);
      else push_token(cst_pkg::K_UNKNOWN, p, 10'd1, 8'd0, 1'b1);
   endtask

   task automatic predict_byte(cst_pkg::req_type r);
      logic [7:0]  b;
      logic [23:0] p;
      bit          again;
      logic        empty;
      b = r.char_code;
      p = byte_pos;
      emitted = 0;
      if (r.end_of_input) begin
         flush_token();
      end else begin
         again = 1;
         case (mode)
            cst_pkg::M_IDENT:
               if (is_letter(b) || is_num(b) || b == "_") begin
                  narrow(b);
                  grow();
                  again = 0;
               end else flush_token();
            cst_pkg::M_NUMBER:
               if (is_num(b)) begin
                  grow();
                  again = 0;
               end else flush_token();
            cst_pkg::M_STRING:
               if (b == 8'h22) begin
                  empty = (cur_len == 10'd1);
                  grow();
                  push_token(cst_pkg::K_STRING, tok_start, cur_len, 8'd0, perr | empty);
                  mode = cst_pkg::M_IDLE;
                  perr = 1'b0;
                  again = 0;
               end else if (b == 8'd32 || b == 8'd33 || (b >= 8'd35 && b <= 8'd126)) begin
                  grow();
                  again = 0;
               end else flush_token();
            cst_pkg::M_LT, cst_pkg::M_GT, cst_pkg::M_BANG, cst_pkg::M_EQ:
               if (b == "=") begin
                  push_token(mode == cst_pkg::M_LT ? cst_pkg::K_LE :
                             mode == cst_pkg::M_GT ? cst_pkg::K_GE :
                             mode == cst_pkg::M_BANG ? cst_pkg::K_NE : cst_pkg::K_EQEQ,
                             tok_start, 10'd2, 8'd0, 1'b0);
                  mode = cst_pkg::M_IDLE;
                  again = 0;
               end else flush_token();
            cst_pkg::M_CHAR_OPEN:
               if (b == 8'h27) begin
                  push_token(cst_pkg::K_CHAR, tok_start, 10'd2, 8'd0, 1'b1);
                  mode = cst_pkg::M_IDLE;
                  again = 0;
               end else if (b == 8'h0a) begin
                  flush_token();
               end else begin
                  held = b;
                  perr = !(is_letter(b) || is_num(b) || b inside {"_", "+", "-", "*", "/"});
                  mode = cst_pkg::M_CHAR_BODY;
                  again = 0;
               end
            cst_pkg::M_CHAR_BODY:
               if (b == 8'h27) begin
                  push_token(cst_pkg::K_CHAR, tok_start, 10'd3, held, perr);
                  mode = cst_pkg::M_IDLE;
                  perr = 1'b0;
                  again = 0;
               end else flush_token();
            default: mode = cst_pkg::M_IDLE;
         endcase
         if (again) scan_fresh(b, p);
         byte_pos = p + 24'd1;
      end
      if (emitted > 0) token_queue[$].last_result = 1'b1;
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      cst_pkg::rsp_type want;
      if (reset) begin
         fail_count = 0;
         token_queue.delete();
         mode = cst_pkg::M_IDLE;
         kw_mask = '1;
         cur_len = '0;
         tok_start = '0;
         byte_pos = '0;
         line_num = 16'd1;
         held = '0;
         perr = 1'b0;
      end else begin
         if (csr_we) line_num = csr_wdata;
         if (rsp_valid && !rsp_stall) begin
            if (token_queue.size() == 0) begin
               report_mismatch("unexpected token", rsp_data.token_kind, -1);
            end else begin
               want = token_queue.pop_front();
               if (rsp_data.token_kind !== want.token_kind)
                  report_mismatch("token_kind", rsp_data.token_kind, want.token_kind);
               if (rsp_data.start_offset !== want.start_offset)
                  report_mismatch("start_offset", rsp_data.start_offset, want.start_offset);
               if (rsp_data.token_length !== want.token_length)
                  report_mismatch("token_length", rsp_data.token_length, want.token_length);
               if (rsp_data.token_line !== want.token_line)
                  report_mismatch("token_line", rsp_data.token_line, want.token_line);
               if (rsp_data.char_value !== want.char_value)
                  report_mismatch("char_value", rsp_data.char_value, want.char_value);
               if (rsp_data.error_flag !== want.error_flag)
                  report_mismatch("error_flag", rsp_data.error_flag, want.error_flag);
               if (rsp_data.last_result !== want.last_result)
                  report_mismatch("last_result", rsp_data.last_result, want.last_result);
            end
         end
         if (req_valid && !req_stall) predict_byte(req_data);
      end
   end

endmodule

FILE: dv/c_subset_token_scanner_tb.sv
// testbench top for the token scanner: stimulus, idling phases and verdict
`timescale 1ns / 100ps
module c_subset_token_scanner_tb;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   cst_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   cst_pkg::rsp_type rsp_data;
   logic             csr_we;
   logic [15:0]      csr_wdata;
   int               fail_count;
   int               tokens_pending;
   int               send_idle_pct;
   int               recv_stall_pct;

   c_subset_token_scanner dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   c_subset_token_scanner_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .tokens_pending(tokens_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // send one byte, with a random idle gap before it per the current phase
   task automatic send_byte(logic [7:0] b, logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.char_code <= b;
      req_data.end_of_input <= eoi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic drain_and_write(logic [15:0] v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // random well-formed lexeme, sometimes noise
   task automatic send_lexeme();
      string words[10] = '{"const", "INT", "Char", "void", "main", "If", "else",
                           "switch", "printf", "default"};
      string ops;
      string puncts;
      int sel;
      ops = "<>!=";
      puncts = "+-*/:;,()[]{}";
      sel = $urandom_range(11);
      case (sel)
         0, 1: send_text(words[$urandom_range(9)]);
         2: repeat ($urandom_range(1, 6))
               send_byte($urandom_range(1) ? 8'($urandom_range("a", "z")) : "_", 1'b0);
         3: repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range("0", "9")), 1'b0);
         4: begin
            send_byte(8'h22, 1'b0);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(35, 126)), 1'b0);
            send_byte(8'h22, 1'b0);
         end
         5: begin
            send_byte(8'h27, 1'b0);
            send_byte(8'($urandom_range(32, 126)), 1'b0);
            send_byte(8'h27, 1'b0);
         end
         6: begin
            send_byte(ops[$urandom_range(3)], 1'b0);
            if ($urandom_range(1)) send_byte("=", 1'b0);
         end
         7: send_byte(puncts[$urandom_range(12)], 1'b0);
         8: send_byte($urandom_range(1) ? 8'h0a : 8'h20, 1'b0);
         9: send_byte(8'($urandom_range(255)), 1'b0);
         10: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
         default: send_byte(8'h20, 1'b0);
      endcase
   endtask

   initial begin
      int rounds;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = 16'd1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: keywords, operators, literals and the error cases
      send_text("RETURN x9 <= >= != == = < > !a ");
      send_text("\"\" \"ab\" '' 'q' '#' '\n");
      send_text("'x; @ \"ab");
      send_byte(8'h0a, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_and_write(16'hffff);
      send_text("a\nb\n");
      send_byte(8'h00, 1'b1);
      // over-long identifier saturates
      for (int i = 0; i < 1030; i++) send_byte("a", 1'b0);
      send_byte(8'h00, 1'b1);
      drain_and_write(16'd1);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 47 : (ph == 3) ? 15 : 0;
         recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 15 : 0;
         rounds = 0;
         while (rounds < 30) begin
            send_lexeme();
            rounds++;
         end
         send_byte(8'h00, 1'b1);
         drain_and_write(ph == 0 ? 16'd500 : ph == 1 ? 16'h8000 : 16'd1);
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_valid <= 1'b0;
      while (tokens_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule
